// File: sv/ltrf_pkg.sv
// Shared types, constants and stamp text helpers for the log timestamp range filter.
`timescale 1ns / 1ps

package ltrf_pkg;

    localparam int STAMP_CHARS = 25;
    localparam int COUNT_W = 5;

    localparam logic [7:0] CHAR_AT = 8'h40;
    localparam logic [7:0] CHAR_NL = 8'h0a;

    localparam logic [1:0] REG_START_HIGH = 2'd0;
    localparam logic [1:0] REG_START_LOW  = 2'd1;
    localparam logic [1:0] REG_STOP_HIGH  = 2'd2;
    localparam logic [1:0] REG_STOP_LOW   = 2'd3;

    typedef enum logic [1:0] {
        ORD_EQ = 2'd0,
        ORD_LT = 2'd1,
        ORD_GT = 2'd2
    } order_t;

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'd0, nib};
        if (nib < 4'd10)
            return 8'h30 + wide;
        else
            return 8'h57 + wide;
    endfunction

    // Character at position pos of the stamp text: '@' then 24 hex digits, high word first.
    function automatic logic [7:0] stamp_char(logic [31:0] high, logic [63:0] low,
                                              logic [COUNT_W-1:0] pos);
        logic [COUNT_W-1:0] idx;
        logic [COUNT_W-1:0] lidx;
        logic [3:0] nib;
        idx  = pos - COUNT_W'(1);
        lidx = idx - COUNT_W'(8);
        if (pos == '0)
            return CHAR_AT;
        else if (pos > COUNT_W'(STAMP_CHARS - 1))
            return 8'h00;
        if (idx < COUNT_W'(8))
            nib = high[(3'd7 - idx[2:0]) * 4 +: 4];
        else
            nib = low[(4'd15 - lidx[3:0]) * 4 +: 4];
        return hex_char(nib);
    endfunction

endpackage

// File: sv/ltrf_cell.sv
// One byte cell of the stamp holding chain.
`timescale 1ns / 1ps

module ltrf_cell
(
    input  logic       clk,
    input  logic       load,
    input  logic [7:0] load_data,
    input  logic       shift,
    input  logic [7:0] shift_data,
    output logic [7:0] data
);

    logic [7:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
        else if (shift)
        begin
            data_reg <= shift_data;
        end
    end

    assign data = data_reg;

endmodule

// File: sv/ltrf_order.sv
// Running lexical order of the held stamp bytes against one bound stamp.
`timescale 1ns / 1ps

module ltrf_order
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        hold,
    input  logic                        clear,
    input  logic [7:0]                  data_byte,
    input  logic [ltrf_pkg::COUNT_W-1:0] pos,
    input  logic [31:0]                 high,
    input  logic [63:0]                 low,
    output ltrf_pkg::order_t            order
);

    ltrf_pkg::order_t order_reg;
    ltrf_pkg::order_t order_next;
    logic [7:0]       ref_char;

    assign ref_char = ltrf_pkg::stamp_char(high, low, pos);

    always_comb
    begin
        order_next = order_reg;
        if (clear)
        begin
            order_next = ltrf_pkg::ORD_EQ;
        end
        else if (hold && order_reg == ltrf_pkg::ORD_EQ)
        begin
            if (data_byte < ref_char)
                order_next = ltrf_pkg::ORD_LT;
            else if (data_byte > ref_char)
                order_next = ltrf_pkg::ORD_GT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ltrf_pkg::ORD_EQ;
        end
        else
        begin
            order_reg <= order_next;
        end
    end

    assign order = order_reg;

endmodule

// File: sv/log_timestamp_range_filter_unit.sv
// Top level of the log timestamp range filter: line control, stamp chain, output register.
// A byte passed straight through is registered and appears on the output in the cycle after it is accepted.
// Throughput: one input word per cycle while lines pass or drop; a stamp release of
// held bytes (plus the byte that ended the stamp, unless it was end_of_file) holds the input
// while the chain shifts them out one per cycle; output stalls hold the input too.
// Reset (rst_n low, asynchronous): line state cleared, start bound zero, stop bound all ones.
`timescale 1ns / 1ps

module log_timestamp_range_filter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: [7:0] in_byte; s_tlast: end_of_file
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    // m_tdata: [7:0] out_byte; m_tlast: last_of_burst
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int CW = ltrf_pkg::COUNT_W;
    localparam int SC = ltrf_pkg::STAMP_CHARS;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_STAMP = 2'd1,
        MODE_PASS  = 2'd2,
        MODE_DROP  = 2'd3
    } mode_t;

    logic [31:0] start_high_reg;
    logic [63:0] start_low_reg;
    logic [31:0] stop_high_reg;
    logic [63:0] stop_low_reg;

    mode_t          mode_reg, mode_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           burst_reg, burst_next;
    logic [CW-1:0]  left_reg, left_next;
    logic           tail_reg, tail_next;
    logic [7:0]     tail_byte_reg, tail_byte_next;
    logic           m_valid_reg, m_valid_next;
    logic [7:0]     m_data_reg, m_data_next;
    logic           m_last_reg, m_last_next;

    ltrf_pkg::order_t start_order;
    ltrf_pkg::order_t stop_order;

    logic [7:0] cell_data [SC];

    logic out_free;
    logic acc;
    logic is_at;
    logic is_nl;
    logic full;
    logic fails;
    logic hold;
    logic clear_ord;
    logic emit_direct;
    logic burst_start;
    logic step;
    logic shift;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !burst_reg && out_free;
    assign acc      = s_tvalid && s_tready;
    assign is_at    = s_tdata == ltrf_pkg::CHAR_AT;
    assign is_nl    = s_tdata == ltrf_pkg::CHAR_NL;
    assign full     = count_reg == CW'(SC);
    assign fails    = full && (start_order == ltrf_pkg::ORD_LT
                               || stop_order != ltrf_pkg::ORD_LT);

    assign hold = acc && !s_tlast
                  && ((mode_reg == MODE_START && is_at)
                      || (mode_reg == MODE_STAMP && !is_nl && !full));
    assign clear_ord = acc && (s_tlast || (mode_reg == MODE_STAMP && (is_nl || full)));
    assign emit_direct = acc && !s_tlast
                         && ((mode_reg == MODE_START && !is_at) || mode_reg == MODE_PASS);
    assign burst_start = acc && mode_reg == MODE_STAMP && !fails
                         && (s_tlast || is_nl || full);
    assign step  = burst_reg && out_free;
    assign shift = step && left_reg != '0;

    // Stamp chain: write at the fill position, shift toward cell 0 on release.
    for (genvar i = 0; i < SC; i++)
    begin : g_cell
        logic [7:0] shift_in;
        if (i < SC - 1)
        begin : g_mid
            assign shift_in = cell_data[i + 1];
        end
        else
        begin : g_end
            assign shift_in = cell_data[i];
        end
        ltrf_cell u_cell
        (
            .clk        (clk),
            .load       (hold && count_reg == CW'(i)),
            .load_data  (s_tdata),
            .shift      (shift),
            .shift_data (shift_in),
            .data       (cell_data[i])
        );
    end

    ltrf_order u_start_order
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold      (hold),
        .clear     (clear_ord),
        .data_byte (s_tdata),
        .pos       (count_reg),
        .high      (start_high_reg),
        .low       (start_low_reg),
        .order     (start_order)
    );

    ltrf_order u_stop_order
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold      (hold),
        .clear     (clear_ord),
        .data_byte (s_tdata),
        .pos       (count_reg),
        .high      (stop_high_reg),
        .low       (stop_low_reg),
        .order     (stop_order)
    );

    always_comb
    begin
        mode_next      = mode_reg;
        count_next     = count_reg;
        burst_next     = burst_reg;
        left_next      = left_reg;
        tail_next      = tail_reg;
        tail_byte_next = tail_byte_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;

        if (acc)
        begin
            if (s_tlast)
            begin
                mode_next  = MODE_START;
                count_next = '0;
            end
            else
            begin
                case (mode_reg)
                    MODE_START:
                    begin
                        if (is_at)
                        begin
                            mode_next  = MODE_STAMP;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            mode_next = is_nl ? MODE_START : MODE_PASS;
                        end
                    end
                    MODE_STAMP:
                    begin
                        if (is_nl || full)
                        begin
                            count_next = '0;
                            if (is_nl)
                                mode_next = MODE_START;
                            else if (fails)
                                mode_next = MODE_DROP;
                            else
                                mode_next = MODE_PASS;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                    MODE_PASS:
                    begin
                        if (is_nl)
                            mode_next = MODE_START;
                    end
                    MODE_DROP:
                    begin
                        if (is_nl)
                            mode_next = MODE_START;
                    end
                    default:
                    begin
                        mode_next = MODE_START;
                    end
                endcase
            end
        end

        if (emit_direct)
        begin
            m_valid_next = 1'b1;
            m_data_next  = s_tdata;
            m_last_next  = 1'b1;
        end

        if (burst_start)
        begin
            burst_next     = 1'b1;
            left_next      = count_reg;
            tail_next      = !s_tlast;
            tail_byte_next = s_tdata;
        end

        // Release held bytes first, then the byte that ended the stamp.
        if (step)
        begin
            m_valid_next = 1'b1;
            if (left_reg != '0)
            begin
                m_data_next = cell_data[0];
                m_last_next = left_reg == CW'(1) && !tail_reg;
                left_next   = left_reg - CW'(1);
                if (left_reg == CW'(1) && !tail_reg)
                    burst_next = 1'b0;
            end
            else
            begin
                m_data_next = tail_byte_reg;
                m_last_next = 1'b1;
                tail_next   = 1'b0;
                burst_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_high_reg <= '0;
            start_low_reg  <= '0;
            stop_high_reg  <= '1;
            stop_low_reg   <= '1;
            mode_reg       <= MODE_START;
            count_reg      <= '0;
            burst_reg      <= 1'b0;
            left_reg       <= '0;
            tail_reg       <= 1'b0;
            tail_byte_reg  <= '0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
            m_last_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ltrf_pkg::REG_START_HIGH: start_high_reg <= cfg_data[31:0];
                    ltrf_pkg::REG_START_LOW:  start_low_reg  <= cfg_data;
                    ltrf_pkg::REG_STOP_HIGH:  stop_high_reg  <= cfg_data[31:0];
                    ltrf_pkg::REG_STOP_LOW:   stop_low_reg   <= cfg_data;
                    default:                  start_high_reg <= start_high_reg;
                endcase
            end
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            burst_reg     <= burst_next;
            left_reg      <= left_next;
            tail_reg      <= tail_next;
            tail_byte_reg <= tail_byte_next;
            m_valid_reg   <= m_valid_next;
            m_data_reg    <= m_data_next;
            m_last_reg    <= m_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: sv/ltrf_checker.sv
// Port-level checks for the log timestamp range filter, bound to the top level.
`timescale 1ns / 1ps

module ltrf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // Output word holds while stalled.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // No input word is taken while the output register is stalled.
    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");

    // A burst in progress blocks the input until its last word is loaded.
    a_burst_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input accepted inside a burst");

    // An end-of-file word never produces a burst that continues into a new file at once.
    a_eof_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !m_tvalid || m_tlast || !s_tready)
        else $error("input open while flush burst still running");

endmodule

bind log_timestamp_range_filter_unit ltrf_checker u_ltrf_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
